FILE: rtl/core/srhc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the slot ring handoff controller.
// No dependencies; every other file in rtl/core uses this package.
package srhc_pkg;

  localparam int unsigned MaxSlots = 64;
  localparam int unsigned SlotIdxW = $clog2(MaxSlots);
  localparam int unsigned CountW   = 7;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned MinSlots = 3;

  typedef enum logic [1:0] {
    SlotEmpty   = 2'd0,
    SlotFull    = 2'd1,
    SlotDumped  = 2'd2,
    SlotAborted = 2'd3
  } slot_e;

  typedef enum logic [ModeW-1:0] {
    ModeMark    = 3'd0,
    ModeRelease = 3'd1,
    ModeDump    = 3'd2,
    ModeAbort   = 3'd3,
    ModeCheck   = 3'd4
  } mode_e;

  // mark full answers
  localparam logic [1:0] FillHanded   = 2'd0;
  localparam logic [1:0] FillOverflow = 2'd1;
  localparam logic [1:0] FillAborted  = 2'd2;

  // producer check answers
  localparam logic [1:0] ProdReady   = 2'd0;
  localparam logic [1:0] ProdWait    = 2'd1;
  localparam logic [1:0] ProdAborted = 2'd2;

  // consumer check answers
  localparam logic [1:0] ConsData   = 2'd0;
  localparam logic [1:0] ConsWait   = 2'd1;
  localparam logic [1:0] ConsNoData = 2'd2;

  localparam logic [CountW-1:0] LevelMax = {CountW{1'b1}};

  // slot memory access request
  typedef struct packed {
    logic                rd_en;
    logic [SlotIdxW-1:0] rd_addr;
    logic                wr_en;
    logic [SlotIdxW-1:0] wr_addr;
    slot_e               wr_data;
  } ram_req_t;

endpackage

FILE: rtl/core/srhc_in_if.sv
`timescale 1ns / 1ps
// Request channel: valid/ready plus one step's mode and slot index.
// Depends on srhc_pkg.
interface srhc_in_if;
  logic                          valid;
  logic                          ready;
  logic [srhc_pkg::ModeW-1:0]    mode;
  logic [srhc_pkg::SlotIdxW-1:0] slot_index;

  modport source (output valid, output mode, output slot_index, input ready);
  modport sink   (input valid, input mode, input slot_index, output ready);
endinterface

FILE: rtl/core/srhc_out_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready plus one step's answer fields.
// Depends on srhc_pkg.
interface srhc_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  fill_status;
  logic [1:0]                  slot_state;
  logic [1:0]                  producer_wait;
  logic [1:0]                  consumer_wait;
  logic [srhc_pkg::CountW-1:0] slots_in_use;
  logic [srhc_pkg::CountW-1:0] peak_in_use;
  logic                        abort_seen;
  logic                        index_error;

  modport source (
    output valid, output fill_status, output slot_state, output producer_wait,
    output consumer_wait, output slots_in_use, output peak_in_use,
    output abort_seen, output index_error, input ready
  );
  modport sink (
    input valid, input fill_status, input slot_state, input producer_wait,
    input consumer_wait, input slots_in_use, input peak_in_use,
    input abort_seen, input index_error, output ready
  );
endinterface

FILE: rtl/core/slot_ring_handoff_controller_unit.sv
`timescale 1ns / 1ps
// Top level of the slot ring handoff controller: slot count register,
// sequencer and slot memory. Depends on srhc_pkg, srhc_in_if, srhc_out_if,
// srhc_slot_ram and srhc_ctrl.
//
//   channel  dir  handshake          payload
//   in_i     in   valid/ready        mode, slot_index
//   out_o    out  valid/ready        fill_status ... index_error
//   cfg      in   cfg_we_i (no wait) cfg_wdata_i = ring length
//
// Steps: mark, release, check and unused modes do a slot read, then
//   modify/write-back and result load, through the single-read-port slot
//   memory. Dump and abort add a sweep over the effective slot count that
//   reads one slot and writes the previous one each cycle, then a drain write.
// Reset: counters and flags clear; per-slot valid bits make every slot read
//   as empty at once, so there is no clearing pass. Slot count resets to 64.
// Stalls: a finished result sits in the output register; the next request is
//   taken while it waits, and the block only holds in its execute cycle when
//   that register is still occupied.
module slot_ring_handoff_controller_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [srhc_pkg::CountW-1:0] cfg_wdata_i,
  srhc_in_if.sink                     in_i,
  srhc_out_if.source                  out_o
);

  localparam logic [srhc_pkg::CountW-1:0] CntMax = srhc_pkg::CountW'(srhc_pkg::MaxSlots);
  localparam logic [srhc_pkg::CountW-1:0] CntMin = srhc_pkg::CountW'(srhc_pkg::MinSlots);

  logic [srhc_pkg::CountW-1:0] ring_len_q, ring_len_d;
  logic [srhc_pkg::CountW-1:0] eff_count;
  srhc_pkg::ram_req_t          ram_req;
  srhc_pkg::slot_e             rd_state;

  // slot count register: to be written only while idle; the block does not enforce this
  assign ring_len_d = cfg_we_i ? cfg_wdata_i : ring_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_len_q <= CntMax;
    end else begin
      ring_len_q <= ring_len_d;
    end
  end

  // clamp into the built range [3, MaxSlots]
  assign eff_count = (ring_len_q > CntMax) ? CntMax :
                     (ring_len_q < CntMin) ? CntMin : ring_len_q;

  srhc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .slot_cnt_i (eff_count),
    .in_i       (in_i),
    .out_o      (out_o),
    .ram_req_o  (ram_req),
    .rd_state_i (rd_state)
  );

  srhc_slot_ram u_slot_ram (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (ram_req),
    .rd_state_o (rd_state)
  );

  // one step at a time: no transfer right after another
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("request taken while a step is in flight");

  // fill level never above the high-water mark
  a_level_le_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.slots_in_use <= out_o.peak_in_use))
    else $error("fill level above peak");

  // a rejected index leaves no slot or fill answer
  a_ierr_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.index_error) |->
      (out_o.slot_state == 2'd0 && out_o.fill_status == srhc_pkg::FillHanded))
    else $error("index error with slot answer");

endmodule

FILE: rtl/core/srhc_slot_ram.sv
`timescale 1ns / 1ps
// Slot state memory: one read and one write port, registered read data.
// Per-entry valid bits make unwritten slots read as empty. Uses srhc_pkg.
module srhc_slot_ram (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  srhc_pkg::ram_req_t req_i,
  output srhc_pkg::slot_e    rd_state_o
);

  logic [1:0]                      mem_q [srhc_pkg::MaxSlots];
  logic [srhc_pkg::MaxSlots-1:0]   valid_q;
  logic [1:0]                      rd_data_q;
  logic                            rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[req_i.rd_addr];
      end
    end
  end

  assign rd_state_o = rd_valid_q ? srhc_pkg::slot_e'(rd_data_q) : srhc_pkg::SlotEmpty;

endmodule

FILE: rtl/core/srhc_ctrl.sv
`timescale 1ns / 1ps
// Step sequencer: read-modify-write of the addressed slot, dump/abort sweep,
// fill counters and the result register. Uses srhc_pkg and both channel interfaces.
module srhc_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [srhc_pkg::CountW-1:0] slot_cnt_i,
  srhc_in_if.sink                     in_i,
  srhc_out_if.source                  out_o,
  output srhc_pkg::ram_req_t          ram_req_o,
  input  srhc_pkg::slot_e             rd_state_i
);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StExec  = 4'b0010,
    StWalk  = 4'b0100,
    StDrain = 4'b1000
  } ctrl_state_e;

  ctrl_state_e                   state_q, state_d;
  srhc_pkg::mode_e               mode_q, mode_d;
  logic [srhc_pkg::SlotIdxW-1:0] idx_q, idx_d;
  logic                          idx_ok_q, idx_ok_d;
  logic [srhc_pkg::SlotIdxW-1:0] last_q, last_d;
  logic [srhc_pkg::SlotIdxW-1:0] ptr_q, ptr_d;
  logic [srhc_pkg::SlotIdxW-1:0] wr_ptr_q, wr_ptr_d;
  logic                          wr_pend_q, wr_pend_d;
  logic [srhc_pkg::CountW-1:0]   level_q, level_d;
  logic [srhc_pkg::CountW-1:0]   peak_q, peak_d;
  logic                          abort_q, abort_d;
  logic                          out_valid_q, out_valid_d;

  logic [1:0]                    res_fill_q, res_fill_d;
  logic [1:0]                    res_slot_q, res_slot_d;
  logic [1:0]                    res_pw_q, res_pw_d;
  logic [1:0]                    res_cw_q, res_cw_d;
  logic [srhc_pkg::CountW-1:0]   res_level_q, res_level_d;
  logic [srhc_pkg::CountW-1:0]   res_peak_q, res_peak_d;
  logic                          res_abort_q, res_abort_d;
  logic                          res_ierr_q, res_ierr_d;

  // step outcome from the slot read
  srhc_pkg::slot_e               new_state;
  logic                          step_wr;
  logic [1:0]                    fill_st, pw, cw;
  logic                          ierr;
  logic [srhc_pkg::CountW-1:0]   lvl_n, peak_n;
  logic                          abort_n;
  logic                          out_free;
  srhc_pkg::slot_e               sweep_state;

  always_comb begin
    new_state = rd_state_i;
    step_wr   = 1'b0;
    fill_st   = srhc_pkg::FillHanded;
    pw        = srhc_pkg::ProdReady;
    cw        = srhc_pkg::ConsData;
    ierr      = 1'b0;
    lvl_n     = level_q;
    abort_n   = abort_q;
    unique case (mode_q)
      srhc_pkg::ModeMark: begin
        ierr = !idx_ok_q;
        if (idx_ok_q) begin
          if (rd_state_i == srhc_pkg::SlotEmpty) begin
            new_state = srhc_pkg::SlotFull;
            step_wr   = 1'b1;
            if (level_q != srhc_pkg::LevelMax) begin
              lvl_n = level_q + 1'b1;
            end
          end else if (rd_state_i == srhc_pkg::SlotAborted) begin
            fill_st = srhc_pkg::FillAborted;
          end else begin
            fill_st = srhc_pkg::FillOverflow;
          end
        end
      end
      srhc_pkg::ModeRelease: begin
        ierr = !idx_ok_q;
        if (idx_ok_q) begin
          if (rd_state_i == srhc_pkg::SlotFull) begin
            new_state = srhc_pkg::SlotEmpty;
            step_wr   = 1'b1;
            if (level_q != '0) begin
              lvl_n = level_q - 1'b1;
            end
          end else if (rd_state_i == srhc_pkg::SlotDumped) begin
            new_state = srhc_pkg::SlotEmpty;
            step_wr   = 1'b1;
          end
        end
      end
      srhc_pkg::ModeDump: begin
        // the sweep does the writes; this only predicts the addressed slot
        if (rd_state_i == srhc_pkg::SlotEmpty) begin
          new_state = srhc_pkg::SlotDumped;
        end
      end
      srhc_pkg::ModeAbort: begin
        new_state = srhc_pkg::SlotAborted;
        abort_n   = 1'b1;
      end
      srhc_pkg::ModeCheck: begin
        ierr = !idx_ok_q;
        if (idx_ok_q) begin
          unique case (rd_state_i)
            srhc_pkg::SlotEmpty: begin
              pw = srhc_pkg::ProdReady;
              cw = srhc_pkg::ConsWait;
            end
            srhc_pkg::SlotFull: begin
              pw = srhc_pkg::ProdWait;
              cw = srhc_pkg::ConsData;
            end
            srhc_pkg::SlotDumped: begin
              pw = srhc_pkg::ProdWait;
              cw = srhc_pkg::ConsNoData;
            end
            srhc_pkg::SlotAborted: begin
              pw = srhc_pkg::ProdAborted;
              cw = srhc_pkg::ConsNoData;
            end
            default: begin
              pw = srhc_pkg::ProdReady;
              cw = srhc_pkg::ConsData;
            end
          endcase
        end
      end
      default: begin
        // unused modes leave slots and counters alone
      end
    endcase
    peak_n = (lvl_n > peak_q) ? lvl_n : peak_q;
  end

  // sweep write value for the entry read last cycle
  assign sweep_state = (mode_q == srhc_pkg::ModeAbort) ? srhc_pkg::SlotAborted :
                       (rd_state_i == srhc_pkg::SlotEmpty) ? srhc_pkg::SlotDumped :
                       rd_state_i;

  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    idx_d       = idx_q;
    idx_ok_d    = idx_ok_q;
    last_d      = last_q;
    ptr_d       = ptr_q;
    wr_ptr_d    = wr_ptr_q;
    wr_pend_d   = wr_pend_q;
    level_d     = level_q;
    peak_d      = peak_q;
    abort_d     = abort_q;
    out_valid_d = out_valid_q && !out_o.ready;
    res_fill_d  = res_fill_q;
    res_slot_d  = res_slot_q;
    res_pw_d    = res_pw_q;
    res_cw_d    = res_cw_q;
    res_level_d = res_level_q;
    res_peak_d  = res_peak_q;
    res_abort_d = res_abort_q;
    res_ierr_d  = res_ierr_q;
    ram_req_o   = '0;

    unique case (state_q)
      StIdle: begin
        if (in_i.valid) begin
          ram_req_o.rd_en   = 1'b1;
          ram_req_o.rd_addr = in_i.slot_index;
          mode_d   = srhc_pkg::mode_e'(in_i.mode);
          idx_d    = in_i.slot_index;
          idx_ok_d = {1'b0, in_i.slot_index} < slot_cnt_i;
          last_d   = srhc_pkg::SlotIdxW'(slot_cnt_i - 1'b1);
          state_d  = StExec;
        end
      end
      StExec: begin
        if (out_free) begin
          ram_req_o.wr_en   = step_wr;
          ram_req_o.wr_addr = idx_q;
          ram_req_o.wr_data = new_state;
          level_d     = lvl_n;
          peak_d      = peak_n;
          abort_d     = abort_n;
          out_valid_d = 1'b1;
          res_fill_d  = fill_st;
          res_slot_d  = idx_ok_q ? new_state : srhc_pkg::SlotEmpty;
          res_pw_d    = pw;
          res_cw_d    = cw;
          res_level_d = lvl_n;
          res_peak_d  = peak_n;
          res_abort_d = abort_n;
          res_ierr_d  = ierr;
          ptr_d       = '0;
          wr_pend_d   = 1'b0;
          if (mode_q == srhc_pkg::ModeDump || mode_q == srhc_pkg::ModeAbort) begin
            state_d = StWalk;
          end else begin
            state_d = StIdle;
          end
        end
      end
      StWalk: begin
        ram_req_o.rd_en   = 1'b1;
        ram_req_o.rd_addr = ptr_q;
        ram_req_o.wr_en   = wr_pend_q;
        ram_req_o.wr_addr = wr_ptr_q;
        ram_req_o.wr_data = sweep_state;
        wr_pend_d = 1'b1;
        wr_ptr_d  = ptr_q;
        if (ptr_q == last_q) begin
          state_d = StDrain;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      StDrain: begin
        ram_req_o.wr_en   = wr_pend_q;
        ram_req_o.wr_addr = wr_ptr_q;
        ram_req_o.wr_data = sweep_state;
        wr_pend_d = 1'b0;
        state_d   = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      wr_pend_q   <= 1'b0;
      level_q     <= '0;
      peak_q      <= '0;
      abort_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_pend_q   <= wr_pend_d;
      level_q     <= level_d;
      peak_q      <= peak_d;
      abort_q     <= abort_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    idx_q       <= idx_d;
    idx_ok_q    <= idx_ok_d;
    last_q      <= last_d;
    ptr_q       <= ptr_d;
    wr_ptr_q    <= wr_ptr_d;
    res_fill_q  <= res_fill_d;
    res_slot_q  <= res_slot_d;
    res_pw_q    <= res_pw_d;
    res_cw_q    <= res_cw_d;
    res_level_q <= res_level_d;
    res_peak_q  <= res_peak_d;
    res_abort_q <= res_abort_d;
    res_ierr_q  <= res_ierr_d;
  end

  assign in_i.ready          = (state_q == StIdle);
  assign out_o.valid         = out_valid_q;
  assign out_o.fill_status   = res_fill_q;
  assign out_o.slot_state    = res_slot_q;
  assign out_o.producer_wait = res_pw_q;
  assign out_o.consumer_wait = res_cw_q;
  assign out_o.slots_in_use  = res_level_q;
  assign out_o.peak_in_use   = res_peak_q;
  assign out_o.abort_seen    = res_abort_q;
  assign out_o.index_error   = res_ierr_q;

endmodule
